FILE: rtl/core/keyed_ducking_gate_top_assert.svh
// ----------------------------------------------------------------------------
// keyed_ducking_gate_top_assert.svh
// Assertion macros for the keyed ducking gate. Each check is sampled on the
// rising clock edge and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef KEYED_DUCKING_GATE_TOP_ASSERT_SVH
`define KEYED_DUCKING_GATE_TOP_ASSERT_SVH

// Same-cycle implication: when cond holds, expr must hold in that cycle.
`define KDG_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication: when cond holds, expr must hold in the next cycle.
`define KDG_ASSERT_NXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/core/kdg_pkg.sv
// ----------------------------------------------------------------------------
// kdg_pkg
// Types, register codes and reset values of the keyed ducking gate.
// ----------------------------------------------------------------------------
package kdg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 24;
  localparam int WLEN_W   = 13;
  localparam int THR_W    = 15;
  localparam int MAG_W    = SAMPLE_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic        [MAG_W-1:0]    mag_t;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH   = 2'd0,
    REG_THRESHOLD_LEVEL = 2'd1,
    REG_ATTACK_STEP     = 2'd2,
    REG_RELEASE_STEP    = 2'd3
  } reg_idx_e;

  localparam gain_t              GAIN_UNITY      = 24'h80_0000;
  localparam logic [WLEN_W-1:0]  WLEN_RESET      = 13'd3840;
  localparam logic [THR_W-1:0]   THR_RESET       = 15'd184;
  localparam gain_t              ATTACK_RESET    = 24'd3495;
  localparam gain_t              RELEASE_RESET   = 24'd291;

  // |x| of a Q15 sample; -32768 gives 32768
  function automatic mag_t sample_mag(input sample_t x);
    mag_t ext;
    ext = {x[SAMPLE_W-1], x};
    sample_mag = x[SAMPLE_W-1] ? (mag_t'(0) - ext) : ext;
  endfunction

endpackage

FILE: rtl/core/keyed_ducking_gate_top.sv
// ----------------------------------------------------------------------------
// keyed_ducking_gate_top
// Mic noise gate keyed by a playback stream: running key magnitude over a
// ring window ducks or releases the mic gain.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while out_stall_i is low; the ring
//   has one read port (at accept) and one write port (as the item leaves
//   stage 1), and a same-entry collision is forwarded, so no window length
//   stalls the input. Pipeline: stage 1, stage 2, stage 3, output register.
// Reset: ring contents are tracked by a fill flag, so there is no clearing
//   pass; the block is ready as soon as rst_ni is released.
module keyed_ducking_gate_top import kdg_pkg::*; #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   key_sample_i,
  input  logic signed [15:0]   mic_sample_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   out_sample_o,
  output logic        [23:0]   gain_level_o,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic        [3:0]    paddr,
  input  logic        [31:0]   pwdata,
  output logic        [31:0]   prdata,
  output logic                 pready
);

  `include "keyed_ducking_gate_top_assert.svh"

  // Index into the ring, length up to and including the depth, and a sum
  // that holds depth * 32768 (also the width of threshold * length).
  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int LEN_W = IDX_W + 1;
  localparam int SUM_W = IDX_W + 16;
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WLEN_W-1:0] wlen_q;
  logic [THR_W-1:0]  thr_q;
  gain_t             attack_q;
  gain_t             release_q;
  logic              cfg_wr;
  logic              wlen_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign wlen_wr = cfg_wr && (cfg_idx == REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= WLEN_RESET;
      thr_q     <= THR_RESET;
      attack_q  <= ATTACK_RESET;
      release_q <= RELEASE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_LENGTH:   wlen_q    <= pwdata[WLEN_W-1:0];
        REG_THRESHOLD_LEVEL: thr_q     <= pwdata[THR_W-1:0];
        REG_ATTACK_STEP:     attack_q  <= pwdata[GAIN_W-1:0];
        REG_RELEASE_STEP:    release_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_LENGTH:   prdata = 32'(wlen_q);
      REG_THRESHOLD_LEVEL: prdata = 32'(thr_q);
      REG_ATTACK_STEP:     prdata = 32'(attack_q);
      REG_RELEASE_STEP:    prdata = 32'(release_q);
      default:             prdata = '0;
    endcase
  end

  // Effective window: zero acts as one, anything past the ring as the ring.
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(wlen_q) > 32'(WINDOW_DEPTH)) begin
      len_eff = LEN_W'(WINDOW_DEPTH);
    end else begin
      len_eff = LEN_W'(wlen_q);
    end
  end

  // Threshold scaled by window length, for the compare two stages past accept.
  // Users must keep config static while items flow; the block does not enforce it.
  logic [SUM_W-1:0] thr_len_q;
  always_ff @(posedge clk_i) begin
    thr_len_q <= SUM_W'(thr_q) * SUM_W'(len_eff);
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: each stage advances into a free or draining slot
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_acc, s1_mv, s2_mv, s3_mv;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign s3_mv   = s3_v_q && out_rdy;
  assign s2_mv   = s2_v_q && s3_rdy;
  assign s1_mv   = s1_v_q && s2_rdy;

  assign in_stall_o = !s1_rdy;
  assign in_acc     = in_valid_i && s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_acc;
      if (s2_rdy)  s2_v_q  <= s1_mv;
      if (s3_rdy)  s3_v_q  <= s2_mv;
      if (out_rdy) out_v_q <= s3_mv;
    end
  end

  // --------------------------------------------------------------------------
  // Accept: advance ring position, issue the memory read of the old entry
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] pos_q;
  logic [IDX_W-1:0] pos_nxt;
  logic [LEN_W-1:0] pos_inc;
  logic             filled_q;   // ring has wrapped once since last clear

  assign pos_inc = {1'b0, pos_q} + LEN_W'(1);
  assign pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else if (wlen_wr) begin
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else if (in_acc) begin
      pos_q    <= pos_nxt;
      if (pos_nxt == '0) filled_q <= 1'b1;
    end
  end

  // Ring memory: read at accept, written when the item leaves stage 1
  logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rd_q;

  // Stage 1 payload
  logic [IDX_W-1:0] s1_pos_q;
  sample_t          s1_key_q;
  sample_t          s1_mic_q;
  mag_t             s1_mag_key_q;
  logic             s1_zero_q;    // entry never written since clear
  logic             s1_fwd_q;     // entry written by the previous item
  mag_t             s1_fwd_mag_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= ring_mem[pos_nxt];
    end
    if (s1_mv) begin
      ring_mem[s1_pos_q] <= s1_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q     <= pos_nxt;
      s1_key_q     <= key_sample_i;
      s1_mic_q     <= mic_sample_i;
      s1_mag_key_q <= sample_mag(key_sample_i);
      s1_zero_q    <= !filled_q;
      // the stage-1 item writes this same entry at this edge
      s1_fwd_q     <= s1_v_q && (s1_pos_q == pos_nxt);
      s1_fwd_mag_q <= s1_mag_key_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: running sum update
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  mag_t             old_mag;

  always_comb begin
    if (s1_fwd_q) begin
      old_mag = s1_fwd_mag_q;
    end else if (s1_zero_q) begin
      old_mag = '0;
    end else begin
      old_mag = sample_mag(sample_t'(rd_q));
    end
  end

  assign sum_d = sum_q + SUM_W'(s1_mag_key_q) - SUM_W'(old_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (wlen_wr) begin
      sum_q <= '0;
    end else if (s1_mv) begin
      sum_q <= sum_d;
    end
  end

  logic [SUM_W-1:0] s2_sum_q;
  sample_t          s2_mic_q;

  always_ff @(posedge clk_i) begin
    if (s1_mv) begin
      s2_sum_q <= sum_d;
      s2_mic_q <= s1_mic_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: level compare and gain ramp
  // --------------------------------------------------------------------------
  gain_t            gain_q;
  gain_t            gain_d;
  logic [GAIN_W:0]  gain_up;

  assign gain_up = {1'b0, gain_q} + {1'b0, release_q};

  always_comb begin
    if (s2_sum_q > thr_len_q) begin
      gain_d = (attack_q >= gain_q) ? '0 : gain_q - attack_q;
    end else begin
      gain_d = (gain_up > {1'b0, GAIN_UNITY}) ? GAIN_UNITY : gain_up[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_UNITY;
    end else if (s2_mv) begin
      gain_q <= gain_d;
    end
  end

  sample_t s3_mic_q;
  gain_t   s3_gain_q;

  always_ff @(posedge clk_i) begin
    if (s2_mv) begin
      s3_mic_q  <= s2_mic_q;
      s3_gain_q <= gain_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: mic * gain, floor shift by 23 into the output register
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod;
  sample_t                  out_sample_q;
  gain_t                    out_gain_q;

  assign prod = PROD_W'(s3_mic_q) * PROD_W'($signed({1'b0, s3_gain_q}));

  always_ff @(posedge clk_i) begin
    if (s3_mv) begin
      out_sample_q <= prod[GAIN_W-1+SAMPLE_W-1:GAIN_W-1];
      out_gain_q   <= s3_gain_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_sample_o = out_sample_q;
  assign gain_level_o = out_gain_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `KDG_ASSERT_NOW(a_pos_in_window, !wlen_wr, {1'b0, pos_q} < len_eff, "ring position past window")
  `KDG_ASSERT_NOW(a_gain_capped, 1'b1, gain_q <= GAIN_UNITY, "gain above unity")
  `KDG_ASSERT_NXT(a_rd_held, s1_v_q && !s1_mv, $stable(rd_q), "stage 1 read data lost")
  `KDG_ASSERT_NXT(a_fwd_taken, in_acc && s1_v_q && (s1_pos_q == pos_nxt), s1_fwd_q,
                  "ring collision not forwarded")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed ducking gate. A driver and a monitor run
// as clocked processes around the block. A local predictor tracks the key
// ring, the running magnitude sum and the gain, and scores every output
// transaction in order. The bench steps through register settings (extremes
// included), burst-shaped key levels that cross the threshold both ways,
// random gaps and stalls on both channels, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb import kdg_pkg::*;;

  localparam int WINDOW_DEPTH = 4096;
  localparam int CYCLE_LIMIT  = 200000;  // well above the slowest legal run
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;     // long output hold-off

  typedef struct packed {
    sample_t key;
    sample_t mic;
  } key_mic_t;

  typedef struct packed {
    sample_t out_sample;
    gain_t   gain_level;
  } duck_res_t;

  // clock, reset and block ports; every input is known from time zero
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  sample_t     key_sample_i = '0;
  sample_t     mic_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  sample_t     out_sample_o;
  gain_t       gain_level_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus and scoreboard
  key_mic_t    pair_q[$];      // transactions waiting for the driver
  duck_res_t   ducked_q[$];    // predicted results, oldest first
  int          n_queued     = 0;
  int          n_accepted   = 0;
  int          n_errors     = 0;
  int          cycle_cnt    = 0;
  logic        in_taken     = 1'b0;
  int          in_idle_pct  = 0;
  int          out_stall_pct = 0;
  int          hold_req     = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;

  // predictor state
  sample_t     key_hist[WINDOW_DEPTH];
  int unsigned wr_pos;
  longint unsigned mag_total;
  gain_t       gain_now;
  logic [WLEN_W-1:0] win_len_reg;
  logic [THR_W-1:0]  thr_reg;
  gain_t       attack_reg;
  gain_t       release_reg;

  keyed_ducking_gate_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_sample_i(key_sample_i),
    .mic_sample_i(mic_sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_sample_o(out_sample_o),
    .gain_level_o(gain_level_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned key_mag(sample_t s);
    int v;
    v = s;                        // sign extends; -32768 gives 32768 below
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_window();
    foreach (key_hist[i]) key_hist[i] = '0;
    wr_pos    = 0;
    mag_total = 0;
  endfunction

  function automatic void gate_reset();
    clear_window();
    gain_now    = GAIN_UNITY;
    win_len_reg = WLEN_RESET;
    thr_reg     = THR_RESET;
    attack_reg  = ATTACK_RESET;
    release_reg = RELEASE_RESET;
  endfunction

  // register write as the block sees it; any window write empties the ring
  function automatic void gate_reg_write(reg_idx_e idx, logic [31:0] val);
    case (idx)
      REG_WINDOW_LENGTH: begin
        win_len_reg = val[WLEN_W-1:0];
        clear_window();
      end
      REG_THRESHOLD_LEVEL: thr_reg     = val[THR_W-1:0];
      REG_ATTACK_STEP:     attack_reg  = val[GAIN_W-1:0];
      REG_RELEASE_STEP:    release_reg = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample pair through the level detector and the gain stage
  function automatic duck_res_t duck_step(sample_t key, sample_t mic);
    duck_res_t       r;
    int unsigned     eff_len;
    longint unsigned level_limit;
    logic [GAIN_W:0] raised;
    longint          prod;
    // zero behaves as one, oversize clamps to the ring depth
    if (win_len_reg == 0)
      eff_len = 1;
    else if (win_len_reg > WINDOW_DEPTH)
      eff_len = WINDOW_DEPTH;
    else
      eff_len = win_len_reg;
    // advance first, then overwrite the oldest entry
    wr_pos = wr_pos + 1;
    if (wr_pos >= eff_len) wr_pos = 0;
    mag_total = mag_total - key_mag(key_hist[wr_pos]) + key_mag(key);
    key_hist[wr_pos] = key;
    level_limit = longint'(thr_reg) * eff_len;
    if (mag_total > level_limit) begin
      gain_now = (attack_reg >= gain_now) ? gain_t'(0) : gain_now - attack_reg;
    end else begin
      raised   = {1'b0, gain_now} + {1'b0, release_reg};
      gain_now = (raised > GAIN_UNITY) ? GAIN_UNITY : raised[GAIN_W-1:0];
    end
    // arithmetic shift: negative products round toward minus infinity
    prod = longint'(mic) * longint'(gain_now);
    r.out_sample = sample_t'(prod >>> 23);
    r.gain_level = gain_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: input transactions are predicted, output transactions scored.
  // Both sampled at the rising edge, before the block's flops update.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    duck_res_t exp_r;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      ducked_q.push_back(duck_step(key_sample_i, mic_sample_i));
      n_accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ducked_q.size() == 0) begin
        $error("unexpected result: out_sample %0d gain_level %0d",
               out_sample_o, gain_level_o);
        n_errors++;
      end else begin
        exp_r = ducked_q.pop_front();
        if (out_sample_o !== exp_r.out_sample) begin
          $error("out_sample: expected %0d, got %0d", exp_r.out_sample, out_sample_o);
          n_errors++;
        end
        if (gain_level_o !== exp_r.gain_level) begin
          $error("gain_level: expected %0d, got %0d", exp_r.gain_level, gain_level_o);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: a new pair goes out only once the held one was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    key_mic_t nxt;
    if (!in_valid_i || in_taken) begin
      if (pair_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = pair_q.pop_front();
        in_valid_i   <= 1'b1;
        key_sample_i <= nxt.key;
        mic_sample_i <= nxt.mic;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long output hold-off, counted here; a request bumps hold_req
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < out_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pair(sample_t k, sample_t m);
    key_mic_t p;
    p.key = k;
    p.mic = m;
    pair_q.push_back(p);
    n_queued++;
  endtask

  // APB write: setup, then access; junk above the field width at random
  task automatic cfg_write(reg_idx_e idx, logic [31:0] val);
    logic [31:0] keep;
    case (idx)
      REG_WINDOW_LENGTH:   keep = (32'd1 << WLEN_W) - 1;
      REG_THRESHOLD_LEVEL: keep = (32'd1 << THR_W) - 1;
      default:             keep = (32'd1 << GAIN_W) - 1;
    endcase
    val = val & keep;
    if ($urandom_range(1)) val = val | ($urandom & ~keep);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    gate_reg_write(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cfg_all(logic [12:0] wl, logic [14:0] th, gain_t at, gain_t rl,
                         bit set_win);
    if (set_win) cfg_write(REG_WINDOW_LENGTH, 32'(wl));
    cfg_write(REG_THRESHOLD_LEVEL, 32'(th));
    cfg_write(REG_ATTACK_STEP, 32'(at));
    cfg_write(REG_RELEASE_STEP, 32'(rl));
  endtask

  // wait until every queued pair is taken and scored, then let the pipe empty
  task automatic settle();
    while (n_accepted != n_queued || ducked_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 52; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 52; end
      default: begin in_idle_pct = 26; out_stall_pct = 26; end
    endcase
  endtask

  function automatic sample_t mic_pick();
    if ($urandom_range(7) != 0) return sample_t'($urandom);
    case ($urandom_range(3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic gain_t step_pick();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_UNITY;
      2: return '1;
      3: return gain_t'($urandom);
      default: return gain_t'($urandom_range(1, 600000));
    endcase
  endfunction

  // key bursts: quiet (below threshold), near threshold, full scale, or a
  // run of -32768 so that even the top threshold can be crossed
  task automatic play_bursts(int n_items);
    int      left;
    int      run;
    int      kind;
    int      amp;
    sample_t k;
    left = n_items;
    while (left > 0) begin
      run  = $urandom_range(1, 24);
      kind = $urandom_range(3);
      if (run > left) run = left;
      case (kind)
        0: amp = thr_reg / 2;
        1: amp = (2 * int'(thr_reg) + 1 > 32767) ? 32767 : 2 * int'(thr_reg) + 1;
        default: amp = 32767;
      endcase
      repeat (run) begin
        if (kind == 3)
          k = -16'sd32768;
        else if (kind == 2)
          k = sample_t'($urandom);
        else
          k = sample_t'(int'($urandom_range(0, 2 * amp)) - amp);
        push_pair(k, mic_pick());
      end
      left -= run;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    sample_t     mic_edge[6];
    logic [12:0] wl;
    logic [14:0] th;
    gain_t       at;
    gain_t       rl;
    gate_reset();
    mic_edge = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd2};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings: full-scale negative keys push the mean over
    // the reset threshold after about 22 transactions, so both the release
    // cap at unity and the attack show up; mic extremes check the rounding.
    set_idling(0);
    for (int i = 0; i < 24; i++)
      push_pair((i % 5 == 4) ? 16'sd32767 : -16'sd32768, mic_edge[i % 6]);
    settle();

    // register extremes
    cfg_all(13'd1, 15'd0, GAIN_UNITY, '1, 1'b1);          // toggles 0 / unity
    play_bursts(40);
    settle();
    set_idling(3);
    cfg_all(13'd0, 15'd32767, '1, '0, 1'b1);              // zero length as one
    play_bursts(40);
    settle();
    set_idling(1);
    cfg_all(13'd8191, 15'd0, '0, 24'd1, 1'b1);            // clamped to depth
    play_bursts(40);
    settle();
    set_idling(2);
    cfg_all(13'd4096, 15'd1, 24'd1, GAIN_UNITY, 1'b1);
    play_bursts(40);
    settle();

    // random settings; the window is kept across some phases so rings wrap
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(9))
        7: wl = 13'($urandom_range(0, 8191));
        8: wl = ($urandom_range(1)) ? 13'd4096 : 13'd2;
        9: wl = 13'($urandom_range(4090, 4100));
        default: wl = 13'($urandom_range(1, 48));
      endcase
      case ($urandom_range(9))
        6: th = 15'($urandom_range(0, 32767));
        7: th = '0;
        8: th = 15'd32767;
        9: th = 15'($urandom_range(1, 200));
        default: th = 15'($urandom_range(0, 3000));
      endcase
      at = step_pick();
      rl = step_pick();
      set_idling(ph % 4);
      cfg_all(wl, th, at, rl, (ph == 0) || ($urandom_range(1) == 1));
      play_bursts(68);
      settle();
    end

    // output held off for a long stretch while the sender keeps offering,
    // so the pipe backs up into the input channel
    set_idling(0);
    cfg_all(13'd16, 15'd500, 24'd40000, 24'd20000, 1'b1);
    hold_req++;
    play_bursts(80);
    settle();

    if (n_errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
